>>> design/sqm_pkg.sv
// Shared types and constants for the signal quality monitor.
package sqm_pkg;

  // Widths of the stream payloads, packed and padded to whole bytes
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned COUNT_W     = 32;
  localparam int unsigned HOLD_W      = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TICKS  = 2'd1;

  // Reset value of the hold register
  localparam logic [HOLD_W-1:0] HOLD_TICKS_RST = 8'd5;

  // Quality codes
  typedef enum logic [2:0] {
    Q_UNKNOWN  = 3'd0,
    Q_NONE     = 3'd1,
    Q_FAINT    = 3'd2,
    Q_BAD      = 3'd3,
    Q_OK       = 3'd4,
    Q_BURSTY   = 3'd5,
    Q_CONSTANT = 3'd6
  } quality_t;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_SCAN,
    ST_FIN,
    ST_PUSH
  } state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // input transfer: capture the tick
    logic eval;  // restart, hold and ring write step
    logic scan;  // issue one history read
    logic fin;   // last compare and quality from the count
    logic push;  // hand the result to the output register
  } sqm_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_scan;  // locked and not held: history must be scanned
    logic scan_last;  // read of the last history entry is being issued
    logic out_free;   // output register can take a result this cycle
  } sqm_stat_t;

endpackage

>>> design/signal_quality_monitor_core.sv
// Top level of the signal quality monitor: controller and datapath.
// A locked tick passes from its input transfer through the eval step, the history scan,
// the final compare and the push; an unlocked or held tick goes from eval to the push;
// one tick is in work at a time, and the push waits while the output is stalled.
// The scan of a locked tick reads the history through the single read port of its RAM.
// Reset (rst_n, synchronous, active low) marks the history empty, sets quality to unknown,
// error_limit to 0 and hold_ticks to 5; a tick can be taken in the cycle after it.
module signal_quality_monitor_core #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [sqm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sqm_pkg::CFG_DATA_W-1:0]     cfg_data,
  // Tick input
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [0] restart, [1] has_lock, [2] has_sync, [3] has_viterbi, [4] has_carrier,
  // [5] has_signal, [37:6] error_blocks, [39:38] zero
  input  logic [sqm_pkg::IN_TDATA_W-1:0]     in_tdata,
  // Result output
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [2:0] quality, [3] changed, [7:4] zero
  output logic [sqm_pkg::OUT_TDATA_W-1:0]    out_tdata
);
  import sqm_pkg::*;

  sqm_cmd_t  cmd;
  sqm_stat_t stat;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  sqm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  sqm_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

>>> design/sqm_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sqm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> design/sqm_ctrl.sv
// Controller state machine that sequences one tick through the datapath.
module sqm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  sqm_pkg::sqm_stat_t stat,
  output sqm_pkg::sqm_cmd_t  cmd
);
  import sqm_pkg::*;

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EVAL;
        end
      end
      ST_EVAL: begin
        cmd.eval = 1'b1;
        if (stat.need_scan) begin
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_PUSH;
      end
      ST_PUSH: begin
        if (stat.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/sqm_dp.sv
// Datapath: configuration, tick registers, hold logic, error history and output register.
module sqm_dp #(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  input  logic [sqm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sqm_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic [sqm_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [sqm_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  sqm_pkg::sqm_cmd_t                    cmd,
  output sqm_pkg::sqm_stat_t                   stat
);
  import sqm_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(HISTORY_DEPTH - 1);

  // Configuration registers
  logic [COUNT_W-1:0] error_limit_r;
  logic [HOLD_W-1:0]  hold_ticks_r;

  // Captured tick
  logic               restart_r, lock_r, sync_r, vit_r, carrier_r, signal_r;
  logic [COUNT_W-1:0] blocks_r;

  // Monitor state
  quality_t           cur_r;
  quality_t           res_r;
  logic [HOLD_W-1:0]  hold_r;
  logic [AW-1:0]      slot_r;
  logic [HISTORY_DEPTH-1:0] hist_vld_r;

  // Scan state
  logic [AW-1:0]      idx_r;
  logic               rd_vld_r;
  logic               rd_ent_vld_r;
  logic [1:0]         over_r;

  // Output register
  logic               out_tvalid_r;
  quality_t           out_quality_r;
  logic               out_changed_r;

  // Evaluation signals
  logic               unk;
  logic [HOLD_W-1:0]  hold_a, hold_b, hold_nxt;
  logic               held;
  logic [COUNT_W-1:0] blocks_eff;
  quality_t           q_nolock;
  logic [COUNT_W-1:0] rd_data;
  logic               hit;
  logic [1:0]         over_cur;
  quality_t           q_lock;

  // Configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      error_limit_r <= '0;
      hold_ticks_r  <= HOLD_TICKS_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ERROR_LIMIT: error_limit_r <= cfg_data;
        CFG_HOLD_TICKS:  hold_ticks_r  <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the tick on its input transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      restart_r <= in_tdata[0];
      lock_r    <= in_tdata[1];
      sync_r    <= in_tdata[2];
      vit_r     <= in_tdata[3];
      carrier_r <= in_tdata[4];
      signal_r  <= in_tdata[5];
      blocks_r  <= in_tdata[37:6];
    end
  end

  // Restart acts first, lock while unknown clears the hold, then the hold test
  always_comb begin
    unk        = restart_r || (cur_r == Q_UNKNOWN);
    hold_a     = restart_r ? hold_ticks_r : hold_r;
    hold_b     = (unk && lock_r) ? '0 : hold_a;
    held       = unk && (hold_b != '0);
    hold_nxt   = held ? (hold_b - HOLD_W'(1)) : hold_b;
    blocks_eff = (unk && !held) ? '0 : blocks_r;
    if (sync_r || vit_r || carrier_r) begin
      q_nolock = Q_BAD;
    end else if (signal_r) begin
      q_nolock = Q_FAINT;
    end else begin
      q_nolock = Q_NONE;
    end
  end

  // History compare; entries never written read as zero
  always_comb begin
    hit      = rd_vld_r && rd_ent_vld_r && (rd_data > error_limit_r);
    over_cur = (hit && (over_r != 2'd2)) ? (over_r + 2'd1) : over_r;
    case (over_cur)
      2'd0:    q_lock = Q_OK;
      2'd1:    q_lock = Q_BURSTY;
      default: q_lock = Q_CONSTANT;
    endcase
  end

  // History ring of past error counts
  sqm_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (cmd.eval && !held && lock_r),
    .waddr (slot_r),
    .wdata (blocks_eff),
    .re    (cmd.scan),
    .raddr (idx_r),
    .rdata (rd_data)
  );

  // Hold counter, ring pointer and per-entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r     <= '0;
      slot_r     <= '0;
      hist_vld_r <= '0;
    end else if (cmd.eval) begin
      hold_r <= hold_nxt;
      if (!held && lock_r) begin
        hist_vld_r[slot_r] <= 1'b1;
        slot_r <= (slot_r == LAST_SLOT) ? '0 : (slot_r + AW'(1));
      end
    end
  end

  // Scan sequencing: read address, read-data valid and errored-entry count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      idx_r  <= '0;
      over_r <= '0;
    end else if (cmd.scan) begin
      idx_r        <= idx_r + AW'(1);
      rd_ent_vld_r <= hist_vld_r[idx_r];
      over_r       <= over_cur;
    end
  end

  // Result of the tick
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      res_r <= held ? Q_UNKNOWN : q_nolock;
    end else if (cmd.fin) begin
      res_r <= q_lock;
    end
  end

  // Current quality follows every delivered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r <= Q_UNKNOWN;
    end else if (cmd.push) begin
      cur_r <= res_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (cmd.push) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_quality_r <= res_r;
      out_changed_r <= (res_r != cur_r);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_changed_r, out_quality_r};

  // Status to the controller
  assign stat.need_scan = lock_r && !held;
  assign stat.scan_last = (idx_r == LAST_SLOT);
  assign stat.out_free  = !out_tvalid_r || out_tready;

endmodule

>>> design/sqm_checker.sv
// Port-level checker for the signal quality monitor, bound to the top level.
module sqm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [sqm_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import sqm_pkg::*;

  // A stalled result holds its data until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // One tick in work at a time: no input transfer straight after another
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a tick is in work");

  // A delivered quality is a defined code and the padding is zero
  a_out_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[2:0] != 3'd7) && (out_tdata[7:4] == 4'd0))
    else $error("bad result encoding");

  // Reset leaves no result pending
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

endmodule

bind signal_quality_monitor_core sqm_checker u_sqm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> verif/tb.sv
// Self-checking testbench for the signal quality monitor: directed and random ticks.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sqm_pkg::*;

  localparam int unsigned DEPTH = 16;

  // One tick as the receiver presents it
  typedef struct {
    logic        restart;
    logic        has_lock;
    logic        has_sync;
    logic        has_viterbi;
    logic        has_carrier;
    logic        has_signal;
    logic [31:0] error_blocks;
  } tick_t;

  // One judgement as the block should report it
  typedef struct {
    quality_t quality;
    logic     changed;
  } verdict_t;

  logic                    clk;
  logic                    rst_n;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_data;
  logic                    in_tvalid;
  logic                    in_tready;
  // [0] restart, [1] has_lock, [2] has_sync, [3] has_viterbi, [4] has_carrier,
  // [5] has_signal, [37:6] error_blocks, [39:38] zero
  logic [IN_TDATA_W-1:0]   in_tdata;
  logic                    out_tvalid;
  logic                    out_tready;
  // [2:0] quality, [3] changed, [7:4] zero
  logic [OUT_TDATA_W-1:0]  out_tdata;

  // Predictor state and register copies
  logic [31:0] hist_counts [DEPTH];
  int unsigned next_slot;
  quality_t    cur_quality;
  logic [7:0]  hold_left;
  logic [31:0] limit_reg;
  logic [7:0]  hold_reg;

  verdict_t    quality_due[$];
  int unsigned err_count;
  int unsigned burst_left;

  signal_quality_monitor_core #(
    .HISTORY_DEPTH(DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Mismatch reporting
  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  // Predictor: judges one tick and updates the shadow state.
  function automatic verdict_t judge_tick(input tick_t t);
    quality_t    prev_quality;
    quality_t    q;
    logic        held;
    logic [31:0] blocks;
    int unsigned over;
    verdict_t    v;
    prev_quality = cur_quality;
    held   = 1'b0;
    blocks = t.error_blocks;
    over   = 0;
    if (t.restart) begin
      cur_quality = Q_UNKNOWN;
      hold_left   = hold_reg;
    end
    if (t.has_sync || t.has_viterbi || t.has_carrier) begin
      q = Q_BAD;
    end else if (t.has_signal) begin
      q = Q_FAINT;
    end else begin
      q = Q_NONE;
    end
    // While unknown, lock ends the hold; the first judged tick loses its count
    if (cur_quality == Q_UNKNOWN) begin
      if (t.has_lock) hold_left = '0;
      if (hold_left != '0) begin
        hold_left = hold_left - 8'd1;
        held      = 1'b1;
      end else begin
        blocks = '0;
      end
    end
    if (!held) begin
      if (t.has_lock) begin
        hist_counts[next_slot] = blocks;
        next_slot = (next_slot == DEPTH - 1) ? 0 : next_slot + 1;
        for (int i = 0; i < DEPTH; i++) begin
          if (hist_counts[i] > limit_reg) over++;
        end
        if (over == 0) q = Q_OK;
        else if (over == 1) q = Q_BURSTY;
        else q = Q_CONSTANT;
      end
      cur_quality = q;
    end
    v.quality = cur_quality;
    v.changed = (cur_quality != prev_quality);
    return v;
  endfunction

  // Sends one tick in the current burst; records the expected verdict on transfer.
  task automatic send_tick(input tick_t t);
    int unsigned gap;
    @(negedge clk);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 60)
                                                : $urandom_range(1, 8);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, t.error_blocks, t.has_signal, t.has_carrier, t.has_viterbi,
                  t.has_sync, t.has_lock, t.restart};
    do @(posedge clk); while (!in_tready);
    quality_due.push_back(judge_tick(t));
  endtask

  // Stops sending and waits until every verdict has come back.
  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (quality_due.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
  endtask

  // Writes one register while the block is idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    settle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ERROR_LIMIT: limit_reg = value;
      CFG_HOLD_TICKS:  hold_reg  = value[7:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic tick_t make_tick(input logic rs, input logic lk, input logic [3:0] fl,
                                      input logic [31:0] blocks);
    tick_t t;
    t.restart      = rs;
    t.has_lock     = lk;
    t.has_sync     = fl[0];
    t.has_viterbi  = fl[1];
    t.has_carrier  = fl[2];
    t.has_signal   = fl[3];
    t.error_blocks = blocks;
    return t;
  endfunction

  // Error count for a locked tick: mostly clean, sometimes at or just over the limit, sometimes any value.
  function automatic logic [31:0] pick_blocks();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return (limit_reg == 0) ? 32'd0 : $urandom_range(0, limit_reg);
    if (r < 70) return limit_reg;
    if (r < 82) return limit_reg + 32'd1;
    if (r < 95) return $urandom;
    return 32'd0;
  endfunction

  // Result checking
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_tvalid && out_tready) begin
      if (quality_due.size() == 0) begin
        report_mismatch($sformatf("result 0x%02h with none expected", out_tdata));
      end else begin
        v = quality_due.pop_front();
        if (out_tdata[2:0] !== v.quality)
          report_mismatch($sformatf("quality %0d, expected %0d", out_tdata[2:0], v.quality));
        if (out_tdata[3] !== v.changed)
          report_mismatch($sformatf("changed %0b, expected %0b", out_tdata[3], v.changed));
      end
    end
  end

  // Receiver back-pressure: stretches of always ready, random stalls and long stalls
  initial begin
    int unsigned mode;
    int unsigned run_left;
    run_left = 0;
    mode     = 0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        mode     = $urandom_range(0, 2);
        run_left = $urandom_range(20, 200);
      end
      run_left--;
      case (mode)
        0:       out_tready <= 1'b1;
        1:       out_tready <= 1'($urandom_range(0, 1));
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Unlocked grades with default registers: none, faint and each bad flag
  task automatic test_unlocked_grades();
    send_tick(make_tick(1'b0, 1'b0, 4'b0000, 32'hFFFF_FFFF));
    send_tick(make_tick(1'b0, 1'b0, 4'b1000, 32'h0000_0000));
    send_tick(make_tick(1'b0, 1'b0, 4'b1001, 32'h5555_5555));
    send_tick(make_tick(1'b0, 1'b0, 4'b0010, 32'hAAAA_AAAA));
    send_tick(make_tick(1'b0, 1'b0, 4'b0100, 32'h0000_0001));
    send_tick(make_tick(1'b0, 1'b0, 4'b1111, 32'h8000_0000));
  endtask

  // Restart: held ticks, the first judged tick, and lock cutting the hold short
  task automatic test_restart_hold();
    send_tick(make_tick(1'b1, 1'b0, 4'b0001, 32'd7));
    repeat (5) send_tick(make_tick(1'b0, 1'b0, 4'b1000, 32'd3));
    send_tick(make_tick(1'b1, 1'b1, 4'b1111, 32'hFFFF_FFFF));
    send_tick(make_tick(1'b1, 1'b0, 4'b0000, 32'd9));
    send_tick(make_tick(1'b0, 1'b1, 4'b0000, 32'hFFFF_FFFF));
  endtask

  // Locked ticks around the limit: ok, bursty, constant
  task automatic test_locked_grades();
    write_reg(CFG_ERROR_LIMIT, 32'd100);
    write_reg(CFG_HOLD_TICKS, 32'd0);
    send_tick(make_tick(1'b0, 1'b1, 4'b0000, 32'd100));
    send_tick(make_tick(1'b0, 1'b1, 4'b0000, 32'd101));
    send_tick(make_tick(1'b0, 1'b1, 4'b1111, 32'hFFFF_FFFF));
    send_tick(make_tick(1'b1, 1'b0, 4'b0000, 32'd0));
    send_tick(make_tick(1'b0, 1'b1, 4'b0000, 32'd50));
  endtask

  // Random ticks in runs: locked stretches, unlocked stretches and retune sequences
  task automatic test_random_phase(input int unsigned count);
    int unsigned done;
    int unsigned len;
    int unsigned kind;
    tick_t       t;
    done = 0;
    while (done < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        len = $urandom_range(5, 40);
        repeat (len) begin
          t = make_tick($urandom_range(0, 29) == 0, 1'b1, 4'($urandom_range(0, 15)),
                        pick_blocks());
          send_tick(t);
          done++;
        end
      end else if (kind < 8) begin
        len = $urandom_range(1, 20);
        repeat (len) begin
          t = make_tick($urandom_range(0, 19) == 0, 1'b0, 4'($urandom_range(0, 15)),
                        $urandom);
          send_tick(t);
          done++;
        end
      end else begin
        send_tick(make_tick(1'b1, $urandom_range(0, 3) == 0, 4'($urandom_range(0, 15)),
                            $urandom));
        done++;
        len = $urandom_range(0, 8);
        repeat (len) begin
          send_tick(make_tick(1'b0, 1'b0, 4'($urandom_range(0, 15)), $urandom));
          done++;
        end
        len = $urandom_range(1, 10);
        repeat (len) begin
          send_tick(make_tick(1'b0, 1'b1, 4'($urandom_range(0, 15)), pick_blocks()));
          done++;
        end
      end
    end
  endtask

  // Random ticks across several register settings, extremes included
  task automatic test_random_settings();
    write_reg(CFG_ERROR_LIMIT, 32'd0);
    write_reg(CFG_HOLD_TICKS, 32'd5);
    test_random_phase(160);
    write_reg(CFG_ERROR_LIMIT, 32'hFFFF_FFFF);
    write_reg(CFG_HOLD_TICKS, 32'd255);
    test_random_phase(160);
    write_reg(CFG_ERROR_LIMIT, $urandom_range(1, 1000));
    write_reg(CFG_HOLD_TICKS, 32'd0);
    test_random_phase(160);
    write_reg(CFG_ERROR_LIMIT, 32'hFFFF_FFFE);
    write_reg(CFG_HOLD_TICKS, 32'd1);
    test_random_phase(160);
    write_reg(CFG_ERROR_LIMIT, $urandom);
    write_reg(CFG_HOLD_TICKS, $urandom_range(0, 255));
    test_random_phase(160);
  endtask

  // Test sequence
  initial begin
    rst_n      = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    out_tready = 1'b0;
    err_count  = 0;
    burst_left = 0;
    for (int i = 0; i < DEPTH; i++) hist_counts[i] = '0;
    next_slot   = 0;
    cur_quality = Q_UNKNOWN;
    hold_left   = '0;
    limit_reg   = '0;
    hold_reg    = HOLD_TICKS_RST;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    test_unlocked_grades();
    test_restart_hold();
    test_locked_grades();
    test_random_settings();

    settle();
    if (err_count == 0 && quality_due.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      if (quality_due.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", quality_due.size()));
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

>>> filelist.f
design/sqm_pkg.sv
design/sqm_ram.sv
design/sqm_ctrl.sv
design/sqm_dp.sv
design/signal_quality_monitor_core.sv
design/sqm_checker.sv
verif/tb.sv
